>>> rtl/grbf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command and status types and the reciprocal table of the Gaussian RBF unit.
package grbf_pkg;

   localparam int MAX_DIM_DEF    = 64;
   localparam int COORD_BITS_DEF = 16;

   localparam int INDEX_BITS = 6;
   localparam int GAUSS_BITS = 16;
   localparam int ACC_BITS   = 40;
   localparam int FRAC_Q     = 32;              // fraction bits of the exponential path
   localparam int MUL_W      = FRAC_Q + 1;      // shared multiplier operand width
   localparam int PROD_W     = 2 * MUL_W;
   localparam int K_BITS     = 4;
   localparam int SQR_BITS   = 2;

   localparam logic [K_BITS-1:0]   LAST_TERM   = 4'd13;
   localparam logic [SQR_BITS-1:0] LAST_SQUARE = 2'd3;

   localparam logic [ACC_BITS-1:0] ACC_MAX   = {ACC_BITS{1'b1}};
   // 12.0 as Q.25: beyond this distance the result rounds to zero
   localparam logic [ACC_BITS-1:0] FAR_LIMIT = 40'd402653184;

   typedef enum logic [1:0] {
      MUL_SQUARE,
      MUL_TERM,
      MUL_RECIP,
      MUL_EXP
   } mul_sel_type;

   typedef struct packed {
      logic              capture;
      logic              acc_update;
      logic              acc_clear;
      logic              exp_init;
      logic              zero_res;
      logic              x_load;
      logic              term_fix;
      logic              sum_update;
      logic              e_cap;
      logic              e_trunc;
      logic              round;
      logic              load_out;
      mul_sel_type       mul_sel;
      logic [K_BITS-1:0] k;
   } dp_cmd_type;

   typedef struct packed {
      logic sample;
      logic last;
      logic far;
   } dp_status_type;

   // floor(2^32 / k); exact quotient follows after one correction step
   function automatic logic [MUL_W-1:0] recip_q32(input logic [K_BITS-1:0] k);
      logic [MUL_W-1:0] m;
      unique case (k)
         4'd1:    m = 33'd4294967296;
         4'd2:    m = 33'd2147483648;
         4'd3:    m = 33'd1431655765;
         4'd4:    m = 33'd1073741824;
         4'd5:    m = 33'd858993459;
         4'd6:    m = 33'd715827882;
         4'd7:    m = 33'd613566756;
         4'd8:    m = 33'd536870912;
         4'd9:    m = 33'd477218588;
         4'd10:   m = 33'd429496729;
         4'd11:   m = 33'd390451572;
         4'd12:   m = 33'd357913941;
         4'd13:   m = 33'd330382099;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

>>> rtl/gaussian_rbf_kernel.sv
`timescale 1ns / 1ps
// Gaussian radial basis unit: top level joining the sequencer and the datapath.
//
// Input channel (req_): one coordinate per item. req_mode low writes the centre
// coordinate req_coord_value at req_coord_index; req_mode high feeds a sample
// coordinate whose squared distance to the stored centre is added to a 40-bit
// saturating accumulator. A sample item with req_last_coord high produces one
// result item on the rsp_ channel: exp(-acc/2) as unsigned Q0.16, after which
// the accumulator restarts at zero.
// Sequence: a centre write leaves the input open; a sample item occupies the unit
// for the memory read, square and accumulate steps. A final sample adds a 13-term
// series evaluated on the shared multiplier, each term a multiply, a reciprocal
// multiply, a correction and a sum, then four squarings, each a multiply and a
// truncation, before rsp_valid rises; a distance beyond the series range skips both.
// The single multiplier and the sequencer that walks it set this order.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled receiver only holds up the unit when a second result is
// ready. Synchronous reset clears the accumulator and the handshakes; the
// centre store keeps its contents until written.
module gaussian_rbf_kernel #(
   parameter int MAX_DIM    = grbf_pkg::MAX_DIM_DEF,
   parameter int COORD_BITS = grbf_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [grbf_pkg::INDEX_BITS-1:0]   req_coord_index,
   input  logic signed [COORD_BITS-1:0]      req_coord_value,
   input  logic                              req_last_coord,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [grbf_pkg::GAUSS_BITS-1:0]   rsp_gauss_value
);
   import grbf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   grbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   grbf_datapath #(
      .MAX_DIM    (MAX_DIM),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_mode),
      .req_coord_index (req_coord_index),
      .req_coord_value (req_coord_value),
      .req_last_coord  (req_last_coord),
      .status          (status),
      .rsp_gauss_value (rsp_gauss_value)
   );

endmodule

>>> rtl/grbf_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the Gaussian RBF unit: item handshakes, series and squaring steps.
module grbf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  grbf_pkg::dp_status_type status,
   output grbf_pkg::dp_cmd_type    cmd
);
   import grbf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_EXP_INIT,
      ST_T_MUL,
      ST_T_REC,
      ST_T_FIX,
      ST_T_SUM,
      ST_E_CAP,
      ST_E_MUL,
      ST_E_TRUNC,
      ST_ROUND,
      ST_OUT
   } state_type;

   state_type           state_ff;
   logic [K_BITS-1:0]   k_ff;
   logic [SQR_BITS-1:0] sqr_ff;
   logic                rsp_valid_ff;
   logic                out_free;

   assign out_free  = !(rsp_valid_ff && rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         sqr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && status.sample) begin
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE: state_ff <= ST_ACCUM;
            ST_ACCUM: begin
               state_ff <= status.last ? ST_EXP_INIT : ST_IDLE;
            end
            ST_EXP_INIT: begin
               k_ff     <= 4'd1;
               state_ff <= status.far ? ST_OUT : ST_T_MUL;
            end
            ST_T_MUL: state_ff <= ST_T_REC;
            ST_T_REC: state_ff <= ST_T_FIX;
            ST_T_FIX: state_ff <= ST_T_SUM;
            ST_T_SUM: begin
               if (k_ff == LAST_TERM) begin
                  state_ff <= ST_E_CAP;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= ST_T_MUL;
               end
            end
            ST_E_CAP: begin
               sqr_ff   <= '0;
               state_ff <= ST_E_MUL;
            end
            ST_E_MUL: state_ff <= ST_E_TRUNC;
            ST_E_TRUNC: begin
               if (sqr_ff == LAST_SQUARE) begin
                  state_ff <= ST_ROUND;
               end else begin
                  sqr_ff   <= sqr_ff + 1'b1;
                  state_ff <= ST_E_MUL;
               end
            end
            ST_ROUND: state_ff <= ST_OUT;
            ST_OUT: begin
               // hold until the output register is free
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MUL_SQUARE;
      cmd.k       = k_ff;
      unique case (state_ff)
         ST_IDLE:     cmd.capture = req_valid;
         ST_SQUARE:   cmd.mul_sel = MUL_SQUARE;
         ST_ACCUM:    cmd.acc_update = 1'b1;
         ST_EXP_INIT: begin
            cmd.acc_clear = 1'b1;
            cmd.zero_res  = status.far;
            cmd.exp_init  = !status.far;
         end
         ST_T_MUL:    cmd.mul_sel = MUL_TERM;
         ST_T_REC: begin
            cmd.mul_sel = MUL_RECIP;
            cmd.x_load  = 1'b1;
         end
         ST_T_FIX:    cmd.term_fix = 1'b1;
         ST_T_SUM:    cmd.sum_update = 1'b1;
         ST_E_CAP:    cmd.e_cap = 1'b1;
         ST_E_MUL:    cmd.mul_sel = MUL_EXP;
         ST_E_TRUNC:  cmd.e_trunc = 1'b1;
         ST_ROUND:    cmd.round = 1'b1;
         ST_OUT:      cmd.load_out = out_free;
         default:     cmd.capture = 1'b0;
      endcase
   end

endmodule

>>> rtl/grbf_datapath.sv
`timescale 1ns / 1ps
// Datapath of the Gaussian RBF unit: mean store, accumulator, shared multiplier, exp series.
module grbf_datapath #(
   parameter int MAX_DIM    = grbf_pkg::MAX_DIM_DEF,
   parameter int COORD_BITS = grbf_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  grbf_pkg::dp_cmd_type                  cmd,
   input  logic                                  req_mode,
   input  logic [grbf_pkg::INDEX_BITS-1:0]       req_coord_index,
   input  logic signed [COORD_BITS-1:0]          req_coord_value,
   input  logic                                  req_last_coord,
   output grbf_pkg::dp_status_type               status,
   output logic [grbf_pkg::GAUSS_BITS-1:0]       rsp_gauss_value
);
   import grbf_pkg::*;

   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int XW = (AW > INDEX_BITS) ? AW : INDEX_BITS;
   localparam int RW = K_BITS + FRAC_Q;

   logic [COORD_BITS-1:0] mean_mem [MAX_DIM];

   logic                  in_range;
   logic [XW-1:0]         idx_ext;
   logic [AW-1:0]         addr;
   logic                  mem_write;
   logic                  mem_read;

   logic [COORD_BITS-1:0] val_ff;
   logic [COORD_BITS-1:0] mean_ff;
   logic                  range_ff;
   logic                  last_ff;
   logic [ACC_BITS-1:0]   acc_ff;
   logic [ACC_BITS-1:0]   acc_in;
   logic [FRAC_Q-1:0]     r_ff;
   logic [MUL_W-1:0]      term_ff;
   logic [MUL_W-1:0]      term_in;
   logic [MUL_W-1:0]      sum_ff;
   logic [MUL_W-1:0]      sum_in;
   logic [FRAC_Q-1:0]     x_ff;
   logic [FRAC_Q-1:0]     e_ff;
   logic [FRAC_Q-1:0]     e_in;
   logic [PROD_W-1:0]     prod_ff;
   logic [PROD_W-1:0]     prod_in;
   logic [GAUSS_BITS-1:0] res_ff;
   logic [GAUSS_BITS-1:0] res_in;
   logic [GAUSS_BITS-1:0] out_ff;

   logic [COORD_BITS-1:0] mean_sel;
   logic [COORD_BITS:0]   diff;
   logic [COORD_BITS:0]   mag;
   logic [MUL_W-1:0]      op_a;
   logic [MUL_W-1:0]      op_b;
   logic [PROD_W-1:0]     acc_sum;
   logic [FRAC_Q-1:0]     q_est;
   logic [RW-1:0]         q_times_k;
   logic [RW-1:0]         rem;
   logic [FRAC_Q:0]       rounded;

   // mean store: write on mode-0 items, read at acceptance of sample items
   assign in_range  = int'(req_coord_index) < MAX_DIM;
   assign idx_ext   = XW'(req_coord_index);
   assign addr      = in_range ? idx_ext[AW-1:0] : '0;
   assign mem_write = cmd.capture && !req_mode && in_range;
   assign mem_read  = cmd.capture && req_mode;

   always_ff @(posedge clock) begin
      if (mem_write) begin
         mean_mem[addr] <= req_coord_value;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_read) begin
         mean_ff <= mean_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_read) begin
         val_ff   <= req_coord_value;
         range_ff <= in_range;
         last_ff  <= req_last_coord;
      end
   end

   // difference and its magnitude
   always_comb begin
      mean_sel = range_ff ? mean_ff : '0;
      diff     = {val_ff[COORD_BITS-1], val_ff} - {mean_sel[COORD_BITS-1], mean_sel};
      mag      = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
   end

   // shared multiplier
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_SQUARE: begin
            op_a = MUL_W'(mag);
            op_b = MUL_W'(mag);
         end
         MUL_TERM: begin
            op_a = term_ff;
            op_b = {1'b0, r_ff};
         end
         MUL_RECIP: begin
            op_a = {1'b0, prod_ff[2*FRAC_Q-1:FRAC_Q]};
            op_b = recip_q32(cmd.k);
         end
         MUL_EXP: begin
            op_a = {1'b0, e_ff};
            op_b = {1'b0, e_ff};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      prod_in = PROD_W'(op_a) * PROD_W'(op_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // saturating distance accumulator
   always_comb begin
      acc_sum = PROD_W'(acc_ff) + prod_ff;
      acc_in  = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (cmd.acc_update) begin
         acc_in = (acc_sum > PROD_W'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // series terms: quotient estimate from the reciprocal, then one correction
   always_comb begin
      q_est     = prod_ff[2*FRAC_Q-1:FRAC_Q];
      q_times_k = RW'(q_est) * RW'(cmd.k);
      rem       = RW'(x_ff) - q_times_k;
      term_in   = (rem >= RW'(cmd.k)) ? (MUL_W'(q_est) + 1'b1) : MUL_W'(q_est);
      sum_in    = cmd.k[0] ? (sum_ff - term_ff) : (sum_ff + term_ff);
      e_in      = sum_ff[FRAC_Q] ? {FRAC_Q{1'b1}} : sum_ff[FRAC_Q-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.exp_init) begin
         // y/16 as Q0.32 is the accumulator shifted up by three
         r_ff    <= {acc_ff[FRAC_Q-4:0], 3'b000};
         term_ff <= {1'b1, {FRAC_Q{1'b0}}};
         sum_ff  <= {1'b1, {FRAC_Q{1'b0}}};
      end else begin
         if (cmd.term_fix) begin
            term_ff <= term_in;
         end
         if (cmd.sum_update) begin
            sum_ff <= sum_in;
         end
      end
      if (cmd.x_load) begin
         x_ff <= prod_ff[2*FRAC_Q-1:FRAC_Q];
      end
      if (cmd.e_cap) begin
         e_ff <= e_in;
      end else if (cmd.e_trunc) begin
         e_ff <= prod_ff[2*FRAC_Q-1:FRAC_Q];
      end
   end

   // round to Q0.16 and saturate; values below one LSB flush to zero
   always_comb begin
      rounded = {1'b0, e_ff} + (FRAC_Q + 1)'(33'h8000);
      if (e_ff[FRAC_Q-1:GAUSS_BITS] == '0) begin
         res_in = '0;
      end else if (rounded[FRAC_Q]) begin
         res_in = {GAUSS_BITS{1'b1}};
      end else begin
         res_in = rounded[FRAC_Q-1:GAUSS_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.zero_res) begin
         res_ff <= '0;
      end else if (cmd.round) begin
         res_ff <= res_in;
      end
      if (cmd.load_out) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_gauss_value = out_ff;
   assign status.sample   = req_mode;
   assign status.last     = last_ff;
   assign status.far      = (acc_ff >= FAR_LIMIT);

endmodule

>>> rtl/grbf_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the Gaussian RBF unit and their binding to the top level.
module grbf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            req_mode,
   input logic                            req_last_coord,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [grbf_pkg::GAUSS_BITS-1:0] rsp_gauss_value
);

   // reset leaves no item pending and the input open
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("unit not idle after reset");

   // a centre write never holds up the next item
   a_write_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_mode) |=> !req_stall)
      else $error("centre write stalled the input");

   // a sample without the last flag frees the input once the square and accumulate steps are done
   a_sample_three_cycles: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_mode && !req_last_coord) |-> ##3 !req_stall)
      else $error("sample item held the input too long");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_gauss_value)))
      else $error("stalled result item dropped or changed");

endmodule

bind gaussian_rbf_kernel grbf_checker u_checker (.*);
